FILE: rtl/afdn_pkg.sv
// Types, constants and pipeline stage functions for the approximate float divider.
`timescale 1ns / 1ps

package afdn_pkg;

  // Number of refinement passes after the seed
  localparam int unsigned REFINE_STEPS = 3;
  // Register stages in one refinement pass
  localparam int unsigned STEP_STAGES  = 13;

  localparam logic [31:0] SEED_MAGIC  = 32'h3F7A_3BEA;
  localparam logic [31:0] DEFAULT_NAN = 32'hFFC0_0000;
  localparam logic [31:0] QNAN_BIT    = 32'h0040_0000;

  // Operands travelling alongside the arithmetic
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] r;
  } item_t;

  // Common input of the final rounding stage
  typedef struct packed {
    logic        special;
    logic [31:0] spec_val;
    logic        sign;
    logic        ovf;
    logic [7:0]  ef;
    logic [23:0] m;
    logic        g;
    logic        s;
  } rnd_t;

  typedef struct packed {
    logic               special;
    logic [31:0]        spec_val;
    logic               sign;
    logic signed [9:0]  ea;
    logic signed [9:0]  eb;
    logic [23:0]        ma;
    logic [23:0]        mb;
  } mul_s1_t;

  typedef struct packed {
    logic               special;
    logic [31:0]        spec_val;
    logic               sign;
    logic signed [9:0]  e;
    logic [47:0]        p;
  } mul_s2_t;

  typedef struct packed {
    logic        special;
    logic [31:0] spec_val;
    logic        sign;
    logic        eff_sub;
    logic [7:0]  ex;
    logic [7:0]  d;
    logic [23:0] mx;
    logic [23:0] my;
  } add_s1_t;

  typedef struct packed {
    logic        special;
    logic [31:0] spec_val;
    logic        sign;
    logic        eff_sub;
    logic [7:0]  ex;
    logic [27:0] sum;
  } add_s2_t;

  // Leading zero count of a 27-bit word
  function automatic logic [4:0] lzc27(logic [26:0] v);
    logic [4:0] cnt;
    logic       found;
    cnt   = 5'd0;
    found = 1'b0;
    for (int i = 26; i >= 0; i--) begin
      if (!found) begin
        if (v[i]) begin
          found = 1'b1;
        end else begin
          cnt = cnt + 5'd1;
        end
      end
    end
    return cnt;
  endfunction

  // Unpack one multiplier operand, subnormals pre-normalised
  function automatic logic [33:0] mul_operand(logic [31:0] x);
    logic [4:0]        lz;
    logic [23:0]       m;
    logic signed [9:0] e;
    if (x[30:23] != 8'd0) begin
      m = {1'b1, x[22:0]};
      e = $signed({2'b00, x[30:23]}) - 10'sd127;
    end else begin
      lz = lzc27({1'b0, x[22:0], 3'b111});
      m  = {1'b0, x[22:0]} << lz;
      e  = -10'sd126 - $signed({5'b00000, lz});
    end
    return {e, m};
  endfunction

  // Multiply stage 1: classify and unpack
  function automatic mul_s1_t mul_unpack(logic [31:0] x, logic [31:0] y);
    mul_s1_t o;
    logic    x_nan, y_nan, x_inf, y_inf, x_zero, y_zero;
    logic [33:0] ux, uy;
    x_nan  = (&x[30:23]) && (|x[22:0]);
    y_nan  = (&y[30:23]) && (|y[22:0]);
    x_inf  = (&x[30:23]) && !(|x[22:0]);
    y_inf  = (&y[30:23]) && !(|y[22:0]);
    x_zero = (x[30:0] == 31'd0);
    y_zero = (y[30:0] == 31'd0);
    ux     = mul_operand(x);
    uy     = mul_operand(y);
    o.sign     = x[31] ^ y[31];
    o.special  = 1'b1;
    o.spec_val = 32'd0;
    if (x_nan) begin
      o.spec_val = x | QNAN_BIT;
    end else if (y_nan) begin
      o.spec_val = y | QNAN_BIT;
    end else if ((x_inf && y_zero) || (x_zero && y_inf)) begin
      o.spec_val = DEFAULT_NAN;
    end else if (x_inf || y_inf) begin
      o.spec_val = {o.sign, 8'hFF, 23'd0};
    end else if (x_zero || y_zero) begin
      o.spec_val = {o.sign, 31'd0};
    end else begin
      o.special = 1'b0;
    end
    o.ea = $signed(ux[33:24]);
    o.ma = ux[23:0];
    o.eb = $signed(uy[33:24]);
    o.mb = uy[23:0];
    return o;
  endfunction

  // Multiply stage 2: mantissa product and exponent sum
  function automatic mul_s2_t mul_product(mul_s1_t i);
    mul_s2_t o;
    o.special  = i.special;
    o.spec_val = i.spec_val;
    o.sign     = i.sign;
    o.e        = i.ea + i.eb;
    o.p        = i.ma * i.mb;
    return o;
  endfunction

  // Multiply stage 3: normalise, denormalise on underflow, collect sticky
  function automatic rnd_t mul_norm(mul_s2_t i);
    rnd_t              o;
    logic [47:0]       p;
    logic signed [9:0] be;
    logic signed [9:0] shv;
    logic [5:0]        sh;
    logic              st;
    st = 1'b0;
    if (i.p[47]) begin
      p  = i.p;
      be = i.e + 10'sd128;
    end else begin
      p  = {i.p[46:0], 1'b0};
      be = i.e + 10'sd127;
    end
    o.ovf = (be > 10'sd254);
    o.ef  = be[7:0];
    if (be < 10'sd1) begin
      shv  = 10'sd1 - be;
      o.ef = 8'd0;
      if (shv > 10'sd47) begin
        st = |p;
        p  = 48'd0;
      end else begin
        sh = shv[5:0];
        st = |(p & ((48'd1 << sh) - 48'd1));
        p  = p >> sh;
      end
    end
    o.special  = i.special;
    o.spec_val = i.spec_val;
    o.sign     = i.sign;
    o.m        = p[47:24];
    o.g        = p[23];
    o.s        = (|p[22:0]) | st;
    return o;
  endfunction

  // Add stage 1: classify, order by magnitude, exponent difference
  function automatic add_s1_t add_unpack(logic [31:0] x, logic [31:0] y, logic neg);
    add_s1_t     o;
    logic [31:0] yy, big, sml;
    logic        x_nan, y_nan, x_inf, y_inf;
    logic [7:0]  eb, es;
    yy    = {y[31] ^ neg, y[30:0]};
    x_nan = (&x[30:23]) && (|x[22:0]);
    y_nan = (&y[30:23]) && (|y[22:0]);
    x_inf = (&x[30:23]) && !(|x[22:0]);
    y_inf = (&y[30:23]) && !(|y[22:0]);
    o.special  = 1'b1;
    o.spec_val = 32'd0;
    if (x_nan) begin
      o.spec_val = x | QNAN_BIT;
    end else if (y_nan) begin
      o.spec_val = y | QNAN_BIT;
    end else if (x_inf && y_inf && (x[31] != yy[31])) begin
      o.spec_val = DEFAULT_NAN;
    end else if (x_inf) begin
      o.spec_val = x;
    end else if (y_inf) begin
      o.spec_val = yy;
    end else begin
      o.special = 1'b0;
    end
    if (x[30:0] >= yy[30:0]) begin
      big = x;
      sml = yy;
    end else begin
      big = yy;
      sml = x;
    end
    eb        = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    es        = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    o.sign    = big[31];
    o.eff_sub = x[31] ^ yy[31];
    o.ex      = eb;
    o.d       = eb - es;
    o.mx      = {|big[30:23], big[22:0]};
    o.my      = {|sml[30:23], sml[22:0]};
    return o;
  endfunction

  // Add stage 2: align the smaller operand and add or subtract
  function automatic add_s2_t add_align(add_s1_t i);
    add_s2_t     o;
    logic [26:0] ys, x27, y27;
    logic        st;
    ys = {i.my, 3'b000};
    if (i.d > 8'd26) begin
      st = |ys;
      ys = 27'd0;
    end else begin
      st = |(ys & ((27'd1 << i.d[4:0]) - 27'd1));
      ys = ys >> i.d[4:0];
    end
    y27 = {ys[26:1], ys[0] | st};
    x27 = {i.mx, 3'b000};
    o.special  = i.special;
    o.spec_val = i.spec_val;
    o.sign     = i.sign;
    o.eff_sub  = i.eff_sub;
    o.ex       = i.ex;
    o.sum      = i.eff_sub ? ({1'b0, x27} - {1'b0, y27}) : ({1'b0, x27} + {1'b0, y27});
    return o;
  endfunction

  // Add stage 3: normalise the sum, bounded by the minimum exponent
  function automatic rnd_t add_norm(add_s2_t i);
    rnd_t        o;
    logic [26:0] n;
    logic [8:0]  ef9;
    logic [4:0]  lz;
    logic [7:0]  lim, sh;
    if (i.sum[27]) begin
      n   = {i.sum[27:2], i.sum[1] | i.sum[0]};
      ef9 = {1'b0, i.ex} + 9'd1;
    end else begin
      lz  = lzc27(i.sum[26:0]);
      lim = i.ex - 8'd1;
      sh  = ({3'b000, lz} < lim) ? {3'b000, lz} : lim;
      n   = i.sum[26:0] << sh;
      ef9 = {1'b0, i.ex} - {1'b0, sh};
      if (!n[26]) begin
        ef9 = 9'd0;
      end
    end
    o.special  = i.special;
    o.spec_val = i.spec_val;
    o.sign     = (i.sum == 28'd0) ? (i.sign & ~i.eff_sub) : i.sign;
    o.ovf      = (ef9 > 9'd254);
    o.ef       = ef9[7:0];
    o.m        = n[26:3];
    o.g        = n[2];
    o.s        = |n[1:0];
    return o;
  endfunction

  // Final stage: round to nearest even and pack
  function automatic logic [31:0] round_pack(rnd_t i);
    logic [30:0] mag;
    logic        inc;
    inc = i.g & (i.s | i.m[0]);
    mag = {i.ef, i.m[22:0]} + {30'd0, inc};
    if (i.special) begin
      return i.spec_val;
    end else if (i.ovf) begin
      return {i.sign, 8'hFF, 23'd0};
    end else begin
      return {i.sign, mag};
    end
  endfunction

endpackage

FILE: rtl/afdn_refine.sv
// One pipelined refinement pass: r <- r - seed(r * b - a).
`timescale 1ns / 1ps

module afdn_refine import afdn_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  item_t item_i,
  output logic  valid_o,
  output item_t item_o
);

  logic [STEP_STAGES-1:0] vld_q;
  item_t                  ctx_q [STEP_STAGES];

  mul_s1_t     m1_q;
  mul_s2_t     m2_q;
  rnd_t        m3_q;
  logic [31:0] prod_q;
  add_s1_t     f1_q;
  add_s2_t     f2_q;
  rnd_t        f3_q;
  logic [31:0] f_q;
  logic [31:0] s_q;
  add_s1_t     n1_q;
  add_s2_t     n2_q;
  rnd_t        n3_q;
  logic [31:0] r_q;

  // Valid bits move with the beats
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[STEP_STAGES-2:0], valid_i};
    end
  end

  // Operand carry line
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctx_q[0] <= item_i;
      for (int i = 1; i < STEP_STAGES; i++) begin
        ctx_q[i] <= ctx_q[i-1];
      end
    end
  end

  // Arithmetic: product, residual, correction, update
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m1_q   <= mul_unpack(item_i.r, item_i.b);
      m2_q   <= mul_product(m1_q);
      m3_q   <= mul_norm(m2_q);
      prod_q <= round_pack(m3_q);
      f1_q   <= add_unpack(prod_q, ctx_q[3].a, 1'b1);
      f2_q   <= add_align(f1_q);
      f3_q   <= add_norm(f2_q);
      f_q    <= round_pack(f3_q);
      s_q    <= f_q - ctx_q[7].b + SEED_MAGIC;
      n1_q   <= add_unpack(ctx_q[8].r, s_q, 1'b1);
      n2_q   <= add_align(n1_q);
      n3_q   <= add_norm(n2_q);
      r_q    <= round_pack(n3_q);
    end
  end

  assign valid_o  = vld_q[STEP_STAGES-1];
  assign item_o.a = ctx_q[STEP_STAGES-1].a;
  assign item_o.b = ctx_q[STEP_STAGES-1].b;
  assign item_o.r = r_q;

endmodule

FILE: rtl/approx_float_divide_newton_top.sv
// Approximate single-precision divider: integer seed and three refinement passes.
// Throughput: one operand pair per cycle; the whole pipeline holds when the
// output beat is not taken, set by the single shared stage enable.
// Reset clears all valid bits; data registers are not reset.
`timescale 1ns / 1ps

module approx_float_divide_newton_top import afdn_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] dividend_bits_i,
  input  logic [31:0] divisor_bits_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] quotient_bits_o
);

  logic  en;
  logic  seed_vld_q;
  item_t seed_q;
  logic  chain_vld [REFINE_STEPS+1];
  item_t chain     [REFINE_STEPS+1];

  // Whole pipe advances unless the output beat is stalled
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // Seed stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_vld_q <= 1'b0;
    end else if (en) begin
      seed_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      seed_q.a <= dividend_bits_i;
      seed_q.b <= divisor_bits_i;
      seed_q.r <= dividend_bits_i - divisor_bits_i + SEED_MAGIC;
    end
  end

  assign chain_vld[0] = seed_vld_q;
  assign chain[0]     = seed_q;

  // Refinement passes in series
  for (genvar k = 0; k < REFINE_STEPS; k++) begin : g_pass
    afdn_refine u_pass (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (chain_vld[k]),
      .item_i  (chain[k]),
      .valid_o (chain_vld[k+1]),
      .item_o  (chain[k+1])
    );
  end

  assign out_valid_o     = chain_vld[REFINE_STEPS];
  assign quotient_bits_o = chain[REFINE_STEPS].r;

endmodule

FILE: rtl/afdn_checker.sv
// Port-level checks for the approximate divider, bound to the top level.
`timescale 1ns / 1ps

module afdn_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [31:0] dividend_bits_i,
  input logic [31:0] divisor_bits_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] quotient_bits_o
);

  // A stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its value
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(quotient_bits_o))
    else $error("result changed while stalled");

  // Input is held back while the output is stalled
  a_stall_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while output stalled");

  // With no result pending the pipe always takes input
  a_free_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input refused with empty output");

endmodule

bind approx_float_divide_newton_top afdn_checker u_afdn_checker (.*);
